### rtl/sequential_list_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shared assertion forms for the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Request codes and the packed word types of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    // Width of one stored key.
    localparam int unsigned KEY_W = 32;

    // Request codes.
    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_DELETE  = 3'd1;
    localparam logic [2:0] REQ_BSEARCH = 3'd2;
    localparam logic [2:0] REQ_LSEARCH = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // Status codes.
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // Request word.
    typedef struct packed {
        logic [2:0]              req_type;
        logic signed [KEY_W-1:0] key;
        logic [6:0]              position;
    } t_req;

    // Response word.
    typedef struct packed {
        logic       status;
        logic [5:0] found_index;
        logic [6:0] count;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/sle_ram.sv
// ----------------------------------------------------------------------------
// Sequential list engine key store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic signed [sle_pkg::KEY_W-1:0]       i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic signed [sle_pkg::KEY_W-1:0]            o_rd_data
);

    logic signed [sle_pkg::KEY_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/sequential_list_engine_top.sv
// ----------------------------------------------------------------------------
// Sequential list engine top level
// Array list of signed keys with insert, delete, clear, binary and linear search.
// ----------------------------------------------------------------------------
// One request word gives one response word. The block takes a request only
// while its sequencer is idle and works on it alone. Every step goes through
// the single read port of the key store, whose read data is registered, and
// through one shared signed compare. Insert at the end of the list writes
// the key directly; insert at an earlier position first moves the entries
// from the last one down to that position up by one, then writes the key.
// Binary search probes at most floor(log2(n)) + 1 midpoints of the n
// entries. Delete runs the binary search and, on a hit, moves every later
// entry down by one. Linear search on a non-empty list compares entries
// from the front while they are below the key. Clear and an unknown request
// go straight to the response. A response is loaded only once the output
// register is free. A new request is taken while the last response still
// waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "sequential_list_engine_top_defines.svh"

module sequential_list_engine_top #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sle_pkg::t_req i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sle_pkg::t_rsp      o_out_word
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned PW = (CW > 7) ? CW : 7;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_BS_RD   = 8'b0000_0010,
        S_BS_CMP  = 8'b0000_0100,
        S_LS_RD   = 8'b0000_1000,
        S_LS_CMP  = 8'b0001_0000,
        S_SHIFT   = 8'b0010_0000,
        S_INS_PUT = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    // Control registers.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;
    logic            r_rd_more, n_rd_more;
    logic            r_pend, n_pend;

    // Working registers.
    logic [2:0]                       r_req, n_req;
    logic signed [sle_pkg::KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]                    r_pos, n_pos;
    logic [CW-1:0]                    r_lo, n_lo;
    logic [CW-1:0]                    r_hb, n_hb;
    logic [AW-1:0]                    r_mid, n_mid;
    logic [CW-1:0]                    r_idx, n_idx;
    logic [AW-1:0]                    r_rd_addr, n_rd_addr;
    logic [AW-1:0]                    r_rd_last, n_rd_last;
    logic [AW-1:0]                    r_dat_addr, n_dat_addr;
    logic                             r_up, n_up;
    logic                             r_status, n_status;
    logic [AW-1:0]                    r_found, n_found;
    sle_pkg::t_rsp                    r_out, n_out;

    // Store port signals.
    logic                             w_wr_en;
    logic [AW-1:0]                    w_wr_addr;
    logic signed [sle_pkg::KEY_W-1:0] w_wr_data;
    logic [AW-1:0]                    w_rd_addr;
    logic signed [sle_pkg::KEY_W-1:0] w_rd_data;

    // Helper values.
    logic [PW-1:0] w_pos_ext;
    logic [PW-1:0] w_cnt_ext;
    logic [PW-1:0] w_found_ext;
    logic [CW-1:0] w_cnt_m1;
    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid_full;
    logic [CW-1:0] w_mid_p1;
    logic [CW-1:0] w_idx_p1;
    logic          w_eq;
    logic          w_lt;
    logic          w_accept;
    logic          w_load;

    sle_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Shared arithmetic: midpoint, bounds and the signed key compare.
    assign w_pos_ext   = PW'(i_in_word.position);
    assign w_cnt_ext   = PW'(r_count);
    assign w_found_ext = PW'(r_found);
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_sum       = (CW + 1)'(r_lo) + (CW + 1)'(r_hb) - (CW + 1)'(1);
    assign w_mid_full  = w_sum[CW:1];
    assign w_mid_p1    = CW'(r_mid) + CW'(1);
    assign w_idx_p1    = r_idx + CW'(1);
    assign w_eq        = (w_rd_data == r_key);
    assign w_lt        = (w_rd_data < r_key);

    // Read address select.
    always_comb begin
        case (r_state)
            S_BS_RD:  w_rd_addr = w_mid_full[AW-1:0];
            S_LS_RD:  w_rd_addr = r_idx[AW-1:0];
            S_LS_CMP: w_rd_addr = w_idx_p1[AW-1:0];
            S_SHIFT:  w_rd_addr = r_rd_addr;
            default:  w_rd_addr = '0;
        endcase
    end

    // Write port: moving entries during a shift, or the new key.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_key;
        if (r_state == S_SHIFT && r_pend) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_up ? (r_dat_addr + AW'(1)) : (r_dat_addr - AW'(1));
            w_wr_data = w_rd_data;
        end else if (r_state == S_INS_PUT) begin
            w_wr_en = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_rd_more   = r_rd_more;
        n_pend      = r_pend;
        n_req       = r_req;
        n_key       = r_key;
        n_pos       = r_pos;
        n_lo        = r_lo;
        n_hb        = r_hb;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_rd_addr   = r_rd_addr;
        n_rd_last   = r_rd_last;
        n_dat_addr  = r_dat_addr;
        n_up        = r_up;
        n_status    = r_status;
        n_found     = r_found;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req    = i_in_word.req_type;
                    n_key    = i_in_word.key;
                    n_pos    = w_pos_ext[AW-1:0];
                    n_found  = '0;
                    n_status = sle_pkg::STAT_FAIL;
                    n_lo     = '0;
                    n_hb     = r_count;
                    n_idx    = '0;
                    n_state  = S_DONE;
                    case (i_in_word.req_type)
                        sle_pkg::REQ_INSERT: begin
                            if (r_count < CW'(CAPACITY) && w_pos_ext <= w_cnt_ext) begin
                                if (w_pos_ext == w_cnt_ext) begin
                                    n_state = S_INS_PUT;
                                end else begin
                                    n_rd_addr = w_cnt_m1[AW-1:0];
                                    n_rd_last = w_pos_ext[AW-1:0];
                                    n_up      = 1'b1;
                                    n_rd_more = 1'b1;
                                    n_pend    = 1'b0;
                                    n_state   = S_SHIFT;
                                end
                            end
                        end
                        sle_pkg::REQ_DELETE, sle_pkg::REQ_BSEARCH: begin
                            n_state = S_BS_RD;
                        end
                        sle_pkg::REQ_LSEARCH: begin
                            if (r_count != '0) begin
                                n_state = S_LS_RD;
                            end
                        end
                        sle_pkg::REQ_CLEAR: begin
                            n_count  = '0;
                            n_status = sle_pkg::STAT_OK;
                        end
                        default: begin
                            n_status = sle_pkg::STAT_FAIL;
                        end
                    endcase
                end
            end

            // Binary search: read the midpoint, or give up when the range is empty.
            S_BS_RD: begin
                if (r_lo < r_hb) begin
                    n_mid   = w_mid_full[AW-1:0];
                    n_state = S_BS_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_BS_CMP: begin
                if (w_eq) begin
                    if (r_req == sle_pkg::REQ_DELETE) begin
                        if (w_mid_p1 < r_count) begin
                            n_rd_addr = w_mid_p1[AW-1:0];
                            n_rd_last = w_cnt_m1[AW-1:0];
                            n_up      = 1'b0;
                            n_rd_more = 1'b1;
                            n_pend    = 1'b0;
                            n_state   = S_SHIFT;
                        end else begin
                            n_count  = w_cnt_m1;
                            n_status = sle_pkg::STAT_OK;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_found  = r_mid;
                        n_status = sle_pkg::STAT_OK;
                        n_state  = S_DONE;
                    end
                end else if (w_lt) begin
                    n_lo    = w_mid_p1;
                    n_state = S_BS_RD;
                end else begin
                    n_hb    = CW'(r_mid);
                    n_state = S_BS_RD;
                end
            end

            S_LS_RD: begin
                n_state = S_LS_CMP;
            end

            // Linear scan: compare entry r_idx while the next one is read.
            S_LS_CMP: begin
                if (w_lt) begin
                    if (w_idx_p1 == r_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = w_idx_p1;
                    end
                end else begin
                    if (w_eq) begin
                        n_found  = r_idx[AW-1:0];
                        n_status = sle_pkg::STAT_OK;
                    end
                    n_state = S_DONE;
                end
            end

            // Shift: one read and one write of the previous read each cycle.
            S_SHIFT: begin
                n_dat_addr = r_rd_addr;
                n_pend     = r_rd_more;
                if (r_rd_more) begin
                    n_rd_more = (r_rd_addr != r_rd_last);
                    n_rd_addr = r_up ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
                end else if (r_up) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_count  = w_cnt_m1;
                    n_status = sle_pkg::STAT_OK;
                    n_state  = S_DONE;
                end
            end

            S_INS_PUT: begin
                n_count  = r_count + CW'(1);
                n_status = sle_pkg::STAT_OK;
                n_state  = S_DONE;
            end

            S_DONE: begin
                if (w_load) begin
                    n_out.status      = r_status;
                    n_out.found_index = w_found_ext[5:0];
                    n_out.count       = w_cnt_ext[6:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_more   <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_more   <= n_rd_more;
            r_pend      <= n_pend;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_lo       <= n_lo;
        r_hb       <= n_hb;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_rd_addr  <= n_rd_addr;
        r_rd_last  <= n_rd_last;
        r_dat_addr <= n_dat_addr;
        r_up       <= n_up;
        r_status   <= n_status;
        r_found    <= n_found;
        r_out      <= n_out;
    end

    // Checks on the sequencer and the store.
    `SLE_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SLE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE, "idle after accept")
    `SLE_ASSERT_NOW(a_wr_in_range, i_clk, i_rst_n, w_wr_en, CW'(w_wr_addr) <= r_count, "write beyond count")
    `SLE_ASSERT_NOW(a_shift_nonempty, i_clk, i_rst_n, r_state == S_SHIFT, r_count != '0, "shift on empty list")

endmodule

`default_nettype wire

### bench/sequential_list_engine_top_test.sv
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Sends insert, delete, search and clear requests through the request
// channel with random gaps, under random back-pressure on the response side. A tracker keeps its own
// copy of the key list and the element count, works out the response word
// for every accepted request and compares it field by field with what the
// engine returns, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_list_engine_top_test;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 120;

    // Keeps a shadow of the key list and the queue of response words still due.
    class key_list_tracker;
        int            keys[CAPACITY];
        int            elem_count;
        sle_pkg::t_rsp expected_q[$];
        int            errors;
        int            checked;
        int            n_insert, n_reject, n_delete, n_miss, n_bsearch, n_lsearch, n_hit;
        int            n_clear, n_other, n_full;

        function new();
            elem_count = 0;
            errors     = 0;
            checked    = 0;
            n_insert   = 0;
            n_reject   = 0;
            n_delete   = 0;
            n_miss     = 0;
            n_bsearch  = 0;
            n_lsearch  = 0;
            n_hit      = 0;
            n_clear    = 0;
            n_other    = 0;
            n_full     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Binary search over the stored keys; -1 when absent.
        function int bin_find(int k);
            int lo, hi, mid;
            lo = 0;
            hi = elem_count - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (keys[mid] == k) return mid;
                if (keys[mid] < k) lo = mid + 1;
                else hi = mid - 1;
            end
            return -1;
        endfunction

        // Scan from the front while the stored key is below the request.
        function int lin_find(int k);
            int i;
            i = 0;
            while (i < elem_count && keys[i] < k) i++;
            if (i == elem_count || keys[i] != k) return -1;
            return i;
        endfunction

        // Apply one accepted request word and queue the response it must give.
        function void note_request(sle_pkg::t_req r);
            sle_pkg::t_rsp e;
            int            k, pos, hit, j;
            k             = r.key;
            pos           = int'(r.position);
            e.status      = sle_pkg::STAT_FAIL;
            e.found_index = '0;
            case (r.req_type)
                sle_pkg::REQ_INSERT: begin
                    n_insert++;
                    if (elem_count < CAPACITY && pos <= elem_count) begin
                        for (j = elem_count; j > pos; j--) keys[j] = keys[j-1];
                        keys[pos] = k;
                        elem_count++;
                        e.status = sle_pkg::STAT_OK;
                        if (elem_count == CAPACITY) n_full++;
                    end else begin
                        n_reject++;
                    end
                end
                sle_pkg::REQ_DELETE: begin
                    n_delete++;
                    hit = bin_find(k);
                    if (hit >= 0) begin
                        for (j = hit; j + 1 < elem_count; j++) keys[j] = keys[j+1];
                        elem_count--;
                        e.status = sle_pkg::STAT_OK;
                    end else begin
                        n_miss++;
                    end
                end
                sle_pkg::REQ_BSEARCH, sle_pkg::REQ_LSEARCH: begin
                    if (r.req_type == sle_pkg::REQ_BSEARCH) begin
                        n_bsearch++;
                        hit = bin_find(k);
                    end else begin
                        n_lsearch++;
                        hit = lin_find(k);
                    end
                    if (hit >= 0) begin
                        n_hit++;
                        e.status      = sle_pkg::STAT_OK;
                        e.found_index = 6'(hit);
                    end
                end
                sle_pkg::REQ_CLEAR: begin
                    n_clear++;
                    elem_count = 0;
                    e.status   = sle_pkg::STAT_OK;
                end
                default: begin
                    n_other++;
                end
            endcase
            e.count = 7'(elem_count);
            expected_q.push_back(e);
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        // Compare one response word with the oldest one still due.
        function void check_response(sle_pkg::t_rsp got);
            sle_pkg::t_rsp want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual status %0d index %0d count %0d",
                         $time, got.status, got.found_index, got.count);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status) report("status", want.status, got.status);
            if (got.found_index !== want.found_index)
                report("found_index", want.found_index, got.found_index);
            if (got.count !== want.count) report("count", want.count, got.count);
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    sle_pkg::t_req  in_word;
    logic           out_valid;
    logic           out_ready;
    sle_pkg::t_rsp  out_word;

    key_list_tracker tracker = new();

    int sent;
    int idle_cycles;
    int stall_left;
    bit steady;

    sequential_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // Free-running clock.
    always #6 clk = ~clk;

    // Gap length: mostly none or short, now and then long; none in steady stretches.
    function int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function sle_pkg::t_req make_req(logic [2:0] op, int k, int p);
        sle_pkg::t_req r;
        r.req_type = op;
        r.key      = k;
        r.position = 7'(p);
        return r;
    endfunction

    // Key mix: small values for duplicates, full range, and the extremes.
    function int pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return int'($urandom_range(0, 40)) - 20;
            5, 6, 7:       return int'($urandom);
            8: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1) == 0) return 32'h8000_0000 + int'($urandom_range(0, 3));
                return 32'h7fff_ffff - int'($urandom_range(0, 3));
            end
        endcase
    endfunction

    // Slot that keeps an ascending list ascending; ties go either side.
    function int sorted_slot(int k);
        int  n, i;
        bit  after_ties;
        n          = 0;
        after_ties = 1'($urandom_range(0, 1));
        for (i = 0; i < tracker.elem_count; i++) begin
            if (tracker.keys[i] < k || (after_ties && tracker.keys[i] == k)) n++;
        end
        return n;
    endfunction

    function int stored_key();
        if (tracker.elem_count == 0) return pick_key();
        return tracker.keys[$urandom_range(0, tracker.elem_count - 1)];
    endfunction

    // Present one request word and hold it until the engine takes it.
    task automatic send_req(input sle_pkg::t_req w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        do @(posedge clk); while (!in_ready);
        tracker.note_request(w);
        sent++;
        @(negedge clk);
    endtask

    task automatic insert_sorted(input int k);
        send_req(make_req(sle_pkg::REQ_INSERT, k, sorted_slot(k)));
    endtask

    // Grow the list in order until it is full, then knock on the full list.
    task automatic fill_list();
        int k;
        while (tracker.elem_count < CAPACITY) begin
            k = pick_key();
            insert_sorted(k);
        end
        repeat ($urandom_range(1, 3)) begin
            send_req(make_req(sle_pkg::REQ_INSERT, pick_key(), $urandom_range(0, CAPACITY)));
        end
    endtask

    // Result side: accept with random stalls.
    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready = 1'b0;
                stall_left--;
            end else begin
                out_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Check every response word that is taken.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) tracker.check_response(out_word);
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("sequential_list_engine_top_test: FAIL");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        int r;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        sent        = 0;
        idle_cycles = 0;
        steady      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty list, bad positions, key extremes, misses, unknown codes, clear.
        send_req(make_req(sle_pkg::REQ_BSEARCH, 0, 0));
        send_req(make_req(sle_pkg::REQ_LSEARCH, 0, 0));
        send_req(make_req(sle_pkg::REQ_DELETE, 0, 0));
        send_req(make_req(sle_pkg::REQ_INSERT, 5, 1));
        send_req(make_req(sle_pkg::REQ_INSERT, 5, 127));
        send_req(make_req(sle_pkg::REQ_INSERT, 0, 0));
        send_req(make_req(sle_pkg::REQ_INSERT, 32'h8000_0000, 0));
        send_req(make_req(sle_pkg::REQ_INSERT, 32'h7fff_ffff, 2));
        send_req(make_req(sle_pkg::REQ_INSERT, -1, 1));
        send_req(make_req(sle_pkg::REQ_BSEARCH, 32'h7fff_ffff, 0));
        send_req(make_req(sle_pkg::REQ_BSEARCH, 32'h8000_0000, 0));
        send_req(make_req(sle_pkg::REQ_LSEARCH, -1, 0));
        send_req(make_req(sle_pkg::REQ_LSEARCH, 5, 0));
        send_req(make_req(sle_pkg::REQ_BSEARCH, 1, 0));
        send_req(make_req(sle_pkg::REQ_LSEARCH, 32'h7fff_ffff, 0));
        send_req(make_req(sle_pkg::REQ_DELETE, 0, 0));
        send_req(make_req(sle_pkg::REQ_DELETE, 7, 0));
        send_req(make_req(3'd5, 32'h5a5a_a5a5, 7'h7f));
        send_req(make_req(3'd6, 0, 0));
        send_req(make_req(3'd7, -1, 64));
        send_req(make_req(sle_pkg::REQ_INSERT, 9, 64));
        send_req(make_req(sle_pkg::REQ_CLEAR, 3, 3));
        send_req(make_req(sle_pkg::REQ_BSEARCH, 32'h8000_0000, 0));
        send_req(make_req(sle_pkg::REQ_INSERT, 42, 0));

        // Random part: mostly ordered traffic on a sorted list, some noise.
        while (sent < RANDOM_ITEMS + 24) begin
            if (sent % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) begin
                fill_list();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    send_req(make_req(sle_pkg::REQ_CLEAR, pick_key(), $urandom_range(0, 127)));
                end else if (r < 24) begin
                    insert_sorted(pick_key());
                end else if (r < 41) begin
                    send_req(make_req(sle_pkg::REQ_DELETE, stored_key(), 0));
                end else if (r < 45) begin
                    send_req(make_req(sle_pkg::REQ_DELETE, pick_key(), 0));
                end else if (r < 58) begin
                    send_req(make_req(sle_pkg::REQ_BSEARCH, stored_key(), 0));
                end else if (r < 63) begin
                    send_req(make_req(sle_pkg::REQ_BSEARCH, pick_key(), 0));
                end else if (r < 76) begin
                    send_req(make_req(sle_pkg::REQ_LSEARCH, stored_key(), 0));
                end else if (r < 81) begin
                    send_req(make_req(sle_pkg::REQ_LSEARCH, pick_key(), 0));
                end else if (r < 84) begin
                    // Out-of-order insert at a legal position.
                    send_req(make_req(sle_pkg::REQ_INSERT, pick_key(),
                                      $urandom_range(0, tracker.elem_count)));
                end else if (r < 88) begin
                    // Insert past the end of the list.
                    send_req(make_req(sle_pkg::REQ_INSERT, pick_key(),
                                      $urandom_range(tracker.elem_count + 1, 127)));
                end else begin
                    send_req(make_req(3'($urandom_range(0, 7)), int'($urandom),
                                      $urandom_range(0, 127)));
                end
            end
        end
        in_valid = 1'b0;

        // Drain the outstanding responses, then watch for strays.
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d inserts (%0d refused), %0d deletes (%0d misses),",
                 sent, tracker.n_insert, tracker.n_reject, tracker.n_delete, tracker.n_miss);
        $display("%0d binary and %0d linear searches (%0d hits), %0d clears, %0d bad codes, %0d fills",
                 tracker.n_bsearch, tracker.n_lsearch, tracker.n_hit, tracker.n_clear,
                 tracker.n_other, tracker.n_full);
        if (tracker.errors == 0) begin
            $display("sequential_list_engine_top_test: PASS");
        end else begin
            $display("sequential_list_engine_top_test: FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sequential_list_engine_top.sv
bench/sequential_list_engine_top_test.sv
